/* src/drcl_pkg.sv */
// ----------------------------------------------------------------------------
// drcl_pkg: shared types and codes for the dirty rectangle list
// Rectangle word layout, bounds type, status and action codes, and the
// containment helpers used by the scan unit and the sequencer.
// ----------------------------------------------------------------------------
package drcl_pkg;

    localparam int MAX_RECTS = 64;
    localparam int IDX_W     = $clog2(MAX_RECTS);
    localparam int CNT_W     = $clog2(MAX_RECTS + 1);
    localparam int COORD_W   = 16;
    localparam int BND_W     = COORD_W + 2;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    localparam logic [2:0] ST_COVERED  = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_APPENDED = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_FLUSHED  = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    // One stored word, x in the low 16 bits, h in the high 16 bits.
    typedef struct packed {
        logic        [COORD_W-1:0] h;
        logic        [COORD_W-1:0] w;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_rect;

    typedef struct packed {
        logic signed [BND_W-1:0] x0;
        logic signed [BND_W-1:0] y0;
        logic signed [BND_W-1:0] x1;
        logic signed [BND_W-1:0] y1;
    } t_bounds;

    typedef struct packed {
        logic ent_holds_new;
        logic new_holds_ent;
    } t_cmp;

    // Edges widened so right and bottom never wrap.
    function automatic t_bounds bounds_of(t_rect r);
        t_bounds b;
        b.x0 = BND_W'(r.x);
        b.y0 = BND_W'(r.y);
        b.x1 = b.x0 + $signed({2'b00, r.w});
        b.y1 = b.y0 + $signed({2'b00, r.h});
        return b;
    endfunction

    function automatic logic holds(t_bounds a, t_bounds b);
        return (a.x0 <= b.x0) && (b.x1 <= a.x1) && (a.y0 <= b.y0) && (b.y1 <= a.y1);
    endfunction

endpackage

/* src/drcl_store.sv */
// ----------------------------------------------------------------------------
// drcl_store: rectangle list storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module drcl_store (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [drcl_pkg::IDX_W-1:0] i_wr_addr,
    input  drcl_pkg::t_rect           i_wr_data,
    input  logic [drcl_pkg::IDX_W-1:0] i_rd_addr,
    output drcl_pkg::t_rect           o_rd_data
);
    import drcl_pkg::*;

    t_rect r_mem [MAX_RECTS];
    t_rect r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/drcl_cmp.sv */
// ----------------------------------------------------------------------------
// drcl_cmp: containment compare unit
// Tests one stored entry against the held new rectangle, both directions.
// ----------------------------------------------------------------------------
module drcl_cmp (
    input  drcl_pkg::t_rect   i_entry,
    input  drcl_pkg::t_bounds i_new_bnd,
    output drcl_pkg::t_cmp    o_cmp
);
    import drcl_pkg::*;

    t_bounds ent_bnd;

    assign ent_bnd             = bounds_of(i_entry);
    assign o_cmp.ent_holds_new = holds(ent_bnd, i_new_bnd);
    assign o_cmp.new_holds_ent = holds(i_new_bnd, ent_bnd);

endmodule

/* src/dirty_rect_coalescing_list_core.sv */
// ----------------------------------------------------------------------------
// dirty_rect_coalescing_list_core: dirty rectangle list with merge on add
// Scans the list on add, one entry per cycle, and streams it out on flush.
// ----------------------------------------------------------------------------
// After an add word is accepted, no new word is taken until the scan ends and
// the result has moved into the output register. The shared compare unit
// checks one stored entry per cycle, fed by the single read port of the list
// memory, and the result then moves into the output register; that last step
// waits while the output register still holds a stalled word. A flush streams
// the entries in order, holding while the output register is stalled; an
// empty flush gives a single word.
// Each add gives one result word; a flush gives one word per entry with last
// set on the final one. A finished result sits in an output register, so the
// next word is taken while it waits.
module dirty_rect_coalescing_list_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [15:0] i_rect_x,
    input  logic [15:0] i_rect_y,
    input  logic [15:0] i_rect_w,
    input  logic [15:0] i_rect_h,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_entry_index,
    output logic [15:0] o_out_x,
    output logic [15:0] o_out_y,
    output logic [15:0] o_out_w,
    output logic [15:0] o_out_h,
    output logic        o_last
);
    import drcl_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    t_rect            r_new, n_new;
    t_bounds          r_new_bnd, n_new_bnd;
    logic [2:0]       r_res_status, n_res_status;
    logic [IDX_W-1:0] r_res_idx, n_res_idx;

    logic             r_o_valid;
    logic [2:0]       r_o_status, n_o_status;
    logic [IDX_W-1:0] r_o_idx, n_o_idx;
    t_rect            r_o_rect, n_o_rect;
    logic             r_o_last, n_o_last;

    logic             in_acc;
    logic             out_free;
    logic             out_load;
    logic             scan_end;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_rect            rd_data;
    t_rect            in_rect;
    t_cmp             cmp;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_o_valid || i_out_ready;
    assign scan_end = (({1'b0, r_idx} + CNT_W'(1)) == r_count);
    assign in_rect  = '{h: i_rect_h, w: i_rect_w, y: i_rect_y, x: i_rect_x};

    drcl_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (r_new),
        .i_rd_addr (n_idx),
        .o_rd_data (rd_data)
    );

    drcl_cmp u_cmp (
        .i_entry   (rd_data),
        .i_new_bnd (r_new_bnd),
        .o_cmp     (cmp)
    );

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_count      = r_count;
        n_new        = r_new;
        n_new_bnd    = r_new_bnd;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        out_load     = 1'b0;
        n_o_status   = r_res_status;
        n_o_idx      = r_res_idx;
        n_o_rect     = '0;
        n_o_last     = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx     = '0;
                    n_new     = in_rect;
                    n_new_bnd = bounds_of(in_rect);
                    if (i_action == ACT_FLUSH) begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                            n_res_idx    = '0;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_FLUSH;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_count != '0 && cmp.ent_holds_new) begin
                    n_res_status = ST_COVERED;
                    n_res_idx    = r_idx;
                    n_state      = S_DONE;
                end else if (r_count != '0 && cmp.new_holds_ent) begin
                    wr_en        = 1'b1;
                    wr_addr      = r_idx;
                    n_res_status = ST_REPLACED;
                    n_res_idx    = r_idx;
                    n_state      = S_DONE;
                end else if (r_count == '0 || scan_end) begin
                    if (r_count == CNT_W'(MAX_RECTS)) begin
                        n_res_status = ST_FULL;
                        n_res_idx    = '0;
                    end else begin
                        wr_en        = 1'b1;
                        wr_addr      = r_count[IDX_W-1:0];
                        n_count      = r_count + CNT_W'(1);
                        n_res_status = ST_APPENDED;
                        n_res_idx    = r_count[IDX_W-1:0];
                    end
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_FLUSH: begin
                // hold the read address while the output register is full
                if (out_free) begin
                    out_load   = 1'b1;
                    n_o_status = ST_FLUSHED;
                    n_o_idx    = r_idx;
                    n_o_rect   = rd_data;
                    n_o_last   = scan_end;
                    if (scan_end) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
            if (out_free) begin
                r_o_valid <= out_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_new        <= n_new;
        r_new_bnd    <= n_new_bnd;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        if (out_load) begin
            r_o_status <= n_o_status;
            r_o_idx    <= n_o_idx;
            r_o_rect   <= n_o_rect;
            r_o_last   <= n_o_last;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_entry_index = r_o_idx;
    assign o_out_x       = r_o_rect.x;
    assign o_out_y       = r_o_rect.y;
    assign o_out_w       = r_o_rect.w;
    assign o_out_h       = r_o_rect.h;
    assign o_last        = r_o_last;

endmodule

/* src/drcl_checker.sv */
// ----------------------------------------------------------------------------
// drcl_checker: port-level checks for the dirty rectangle list
// Watches the top level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module drcl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic [5:0]  o_entry_index,
    input logic [15:0] o_out_x,
    input logic [15:0] o_out_y,
    input logic [15:0] o_out_w,
    input logic [15:0] o_out_h,
    input logic        o_last
);
    import drcl_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_entry_index) && $stable(o_last))
        else $error("stalled result word changed");

    // every word starts a multi-cycle job
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after an accepted word");

    // add and empty-flush results are single words with zero rectangle fields
    a_non_flush_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_FLUSHED |-> o_last && o_out_x == '0
            && o_out_y == '0 && o_out_w == '0 && o_out_h == '0)
        else $error("non-flush result carries rectangle data");

    a_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL || o_status == ST_EMPTY)
            |-> o_entry_index == '0)
        else $error("full or empty result with nonzero index");

endmodule

bind dirty_rect_coalescing_list_core drcl_checker u_drcl_checker (.*);
